// ----- sv/disk_window_coverage_filter_unit_assert.svh -----
// Assertion macros shared by the disc coverage filter modules.
// Expects aclk and aresetn in the scope of each use; no other dependencies.
`ifndef DISK_WINDOW_COVERAGE_FILTER_UNIT_ASSERT_SVH
`define DISK_WINDOW_COVERAGE_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DWCF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define DWCF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DWCF_ASSERT_IMP(name, ante, cons, msg)
`define DWCF_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ----- sv/dwcf_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the
// disc coverage filter. No dependencies.
package dwcf_pkg;

    localparam int MAX_WIDTH  = 64;   // power of two: address is {row, col}
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_RADIUS = 15;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_W    = 8;
    localparam int OUT_W    = 8;
    localparam int DIM_W    = 7;
    localparam int RADCFG_W = 4;
    localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W    = RAD_W + 1;
    localparam int SQ_W     = 2 * OFS_W;
    localparam int CNT_W    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int NUM_W    = CNT_W + OUT_W;
    localparam int DCNT_W   = $clog2(NUM_W + 1);

    localparam int FULL_SCALE = 255;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISC_RADIUS  = 2'd2;

    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 7'd64;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 7'd64;
    localparam logic [RADCFG_W-1:0] RADIUS_RESET = 4'd1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic load;         // write the accepted pixel
        logic start;        // latch query center, reset scan and counts
        logic step;         // read one window position, advance
        logic div_load;     // load divider from the counts
        logic div_step;     // one restoring division step
        logic result_load;  // move quotient into the output register
    } dwcf_cmd_t;

    typedef struct packed {
        logic scan_last;    // current position is the last of the window
        logic div_last;     // current division step is the last
        logic out_busy;     // output register holds an untaken beat
    } dwcf_status_t;

endpackage

// ----- sv/disk_window_coverage_filter_unit.sv -----
// Top level of the disc coverage filter: stream ports, config write port,
// controller and datapath. Depends on dwcf_pkg, dwcf_ctrl, dwcf_datapath.
//
//  channel | direction | beat carries
//  --------+-----------+-------------------------------------------------
//  s_axis  | in        | load pixel (tuser 0) or query center (tuser 1)
//  m_axis  | out       | filtered_value, one beat per query
//  cfg     | in        | register index and write data
//
// A load beat writes the mask store at its accept edge. A query makes one
// mask store read per window position through the single read port, then
// an 18-step restoring division.
// Reset is synchronous, active low; it restores the config registers and
// needs no clearing pass, since the mask store is undefined until loaded.
// A finished result waits in the output register while the next beat is taken;
// a query done while that register is still full holds until it drains.
module disk_window_coverage_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [5:0] col, [11:6] row, [19:12] pixel_value, pad
    input  logic        s_axis_tuser,   // [0] mode

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] filtered_value

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    dwcf_pkg::dwcf_cmd_t    cmd;
    dwcf_pkg::dwcf_status_t status;

    // the user must write config only while idle; the block does not enforce it: always take it
    assign cfg_ready = 1'b1;

    dwcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_mode  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    dwcf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_col    (s_axis_tdata[5:0]),
        .in_row    (s_axis_tdata[11:6]),
        .in_pixel  (s_axis_tdata[19:12]),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_axis_tready),
        .m_tvalid  (m_axis_tvalid),
        .m_tdata   (m_axis_tdata)
    );

endmodule

// ----- sv/dwcf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwcf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/dwcf_ctrl.sv -----
// Sequencer for the disc coverage filter: accept, scan, divide, deliver.
// Depends on dwcf_pkg and the assertion macro header.
`include "disk_window_coverage_filter_unit_assert.svh"

module dwcf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_mode,
    output logic                  s_ready,
    input  dwcf_pkg::dwcf_status_t status,
    output dwcf_pkg::dwcf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIVL,
        ST_DIV,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_mode == dwcf_pkg::MODE_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            // let the last read land in the counts
            ST_DRAIN: begin
                state_next = ST_DIVL;
            end
            ST_DIVL: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!status.out_busy) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `DWCF_ASSERT_IMP(a_cmd_onehot, 1'b1,
        $onehot0({cmd.load, cmd.start, cmd.step, cmd.div_load, cmd.div_step, cmd.result_load}),
        "controller issued two commands at once")
    `DWCF_ASSERT_IMP(a_result_free, cmd.result_load, !status.out_busy,
        "result loaded over an untaken output beat")
    `DWCF_ASSERT_NEXT(a_scan_to_drain, (state_reg == ST_SCAN) && status.scan_last,
        state_reg == ST_DRAIN, "scan did not end after the last window position")

endmodule

// ----- sv/dwcf_datapath.sv -----
// Datapath of the disc coverage filter: config registers, mask store, window
// scan, counters, restoring divider and output register.
// Depends on dwcf_pkg, dwcf_ram and the assertion macro header.
`include "disk_window_coverage_filter_unit_assert.svh"

module dwcf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dwcf_pkg::dwcf_cmd_t                 cmd,
    output dwcf_pkg::dwcf_status_t              status,
    input  logic [dwcf_pkg::COL_W-1:0]          in_col,
    input  logic [dwcf_pkg::ROW_W-1:0]          in_row,
    input  logic [dwcf_pkg::PIX_W-1:0]          in_pixel,
    input  logic                                cfg_valid,
    input  logic [dwcf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwcf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [dwcf_pkg::OUT_W-1:0]          m_tdata
);

    localparam int XP_W = dwcf_pkg::COL_W + 2;
    localparam int YP_W = dwcf_pkg::ROW_W + 2;

    // configuration
    logic [dwcf_pkg::DIM_W-1:0]    width_reg, height_reg;
    logic [dwcf_pkg::RADCFG_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= dwcf_pkg::WIDTH_RESET;
            height_reg <= dwcf_pkg::HEIGHT_RESET;
            radius_reg <= dwcf_pkg::RADIUS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dwcf_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                dwcf_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                dwcf_pkg::CFG_DISC_RADIUS:  radius_reg <= cfg_data[dwcf_pkg::RADCFG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [dwcf_pkg::DIM_W-1:0] eff_w, eff_h;
    logic [dwcf_pkg::RAD_W-1:0] eff_r;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = dwcf_pkg::DIM_W'(1);
        end else if (width_reg > dwcf_pkg::DIM_W'(dwcf_pkg::MAX_WIDTH)) begin
            eff_w = dwcf_pkg::DIM_W'(dwcf_pkg::MAX_WIDTH);
        end else begin
            eff_w = width_reg;
        end
        if (height_reg == '0) begin
            eff_h = dwcf_pkg::DIM_W'(1);
        end else if (height_reg > dwcf_pkg::DIM_W'(dwcf_pkg::MAX_HEIGHT)) begin
            eff_h = dwcf_pkg::DIM_W'(dwcf_pkg::MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
        if (32'(radius_reg) > dwcf_pkg::MAX_RADIUS) begin
            eff_r = dwcf_pkg::RAD_W'(dwcf_pkg::MAX_RADIUS);
        end else begin
            eff_r = dwcf_pkg::RAD_W'(radius_reg);
        end
    end

    // mask write on load
    logic load_inside;
    assign load_inside = ({1'b0, in_col} < eff_w) && ({1'b0, in_row} < eff_h);

    // query center and scan offsets
    logic [dwcf_pkg::COL_W-1:0]        qcol_reg;
    logic [dwcf_pkg::ROW_W-1:0]        qrow_reg;
    logic                              qinside_reg;
    logic signed [dwcf_pkg::OFS_W-1:0] dx_reg, dy_reg;
    logic signed [dwcf_pkg::OFS_W-1:0] r_s;

    assign r_s = $signed({1'b0, eff_r});

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            qcol_reg    <= in_col;
            qrow_reg    <= in_row;
            qinside_reg <= load_inside;
            dx_reg      <= -r_s;
            dy_reg      <= -r_s;
        end else if (cmd.step) begin
            if (dx_reg == r_s) begin
                dx_reg <= -r_s;
                dy_reg <= dy_reg + dwcf_pkg::OFS_W'(1);
            end else begin
                dx_reg <= dx_reg + dwcf_pkg::OFS_W'(1);
            end
        end
    end

    assign status.scan_last = (dx_reg == r_s) && (dy_reg == r_s);

    // position and disc test
    logic signed [XP_W-1:0]             x_pos;
    logic signed [YP_W-1:0]             y_pos;
    logic signed [dwcf_pkg::SQ_W-1:0]   dx_ext, dy_ext;
    logic [dwcf_pkg::SQ_W-1:0]          dx_sq, dy_sq;
    logic [dwcf_pkg::SQ_W:0]            dist2, r_ext, r2;
    logic                               pos_img, pos_disc;

    always_comb begin
        x_pos  = $signed({2'b00, qcol_reg}) + XP_W'(dx_reg);
        y_pos  = $signed({2'b00, qrow_reg}) + YP_W'(dy_reg);
        dx_ext = dwcf_pkg::SQ_W'(dx_reg);
        dy_ext = dwcf_pkg::SQ_W'(dy_reg);
        dx_sq  = dx_ext * dx_ext;
        dy_sq  = dy_ext * dy_ext;
        dist2  = {1'b0, dx_sq} + {1'b0, dy_sq};
        r_ext  = (dwcf_pkg::SQ_W + 1)'(eff_r);
        r2     = r_ext * r_ext;
        pos_img = (x_pos >= 0) && (x_pos < $signed(XP_W'(eff_w)))
               && (y_pos >= 0) && (y_pos < $signed(YP_W'(eff_h)));
        pos_disc = dist2 <= r2;
    end

    logic [dwcf_pkg::ADDR_W-1:0] waddr, raddr;
    logic                        rd_bit;

    assign waddr = {in_row, in_col};
    assign raddr = {y_pos[dwcf_pkg::ROW_W-1:0], x_pos[dwcf_pkg::COL_W-1:0]};

    dwcf_ram #(
        .WIDTH (1),
        .DEPTH (dwcf_pkg::DEPTH)
    ) u_mask (
        .aclk  (aclk),
        .we    (cmd.load && load_inside),
        .waddr (waddr),
        .wdata (in_pixel != '0),
        .re    (cmd.step),
        .raddr (raddr),
        .rdata (rd_bit)
    );

    // counts, taken from the registered read bit and hit flag; an off-image center counts nothing
    logic                       hit_reg;
    logic [dwcf_pkg::CNT_W-1:0] all_reg, set_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
            all_reg <= '0;
            set_reg <= '0;
        end else begin
            hit_reg <= cmd.step && qinside_reg && pos_img && pos_disc;
            if (cmd.start) begin
                all_reg <= '0;
                set_reg <= '0;
            end else if (hit_reg) begin
                all_reg <= all_reg + dwcf_pkg::CNT_W'(1);
                set_reg <= set_reg + dwcf_pkg::CNT_W'(rd_bit);
            end
        end
    end

    // restoring divider: quotient shifts into num_reg
    logic [dwcf_pkg::NUM_W-1:0]  num_reg;
    logic [dwcf_pkg::CNT_W-1:0]  rem_reg;
    logic [dwcf_pkg::DCNT_W-1:0] div_cnt_reg;
    logic [dwcf_pkg::CNT_W:0]    rem_sh, rem_sub;
    logic                        rem_ge;

    always_comb begin
        rem_sh  = {rem_reg, num_reg[dwcf_pkg::NUM_W-1]};
        rem_ge  = rem_sh >= {1'b0, all_reg};
        rem_sub = rem_sh - {1'b0, all_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_load) begin
            num_reg     <= dwcf_pkg::NUM_W'(set_reg) * dwcf_pkg::NUM_W'(dwcf_pkg::FULL_SCALE);
            rem_reg     <= '0;
            div_cnt_reg <= dwcf_pkg::DCNT_W'(dwcf_pkg::NUM_W);
        end else if (cmd.div_step) begin
            num_reg     <= {num_reg[dwcf_pkg::NUM_W-2:0], rem_ge};
            rem_reg     <= rem_ge ? rem_sub[dwcf_pkg::CNT_W-1:0] : rem_sh[dwcf_pkg::CNT_W-1:0];
            div_cnt_reg <= div_cnt_reg - dwcf_pkg::DCNT_W'(1);
        end
    end

    assign status.div_last = div_cnt_reg == dwcf_pkg::DCNT_W'(1);

    // output register
    logic                       m_valid_reg;
    logic [dwcf_pkg::OUT_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.result_load) begin
            m_data_reg <= qinside_reg ? num_reg[dwcf_pkg::OUT_W-1:0] : '0;
        end
    end

    assign status.out_busy = m_valid_reg && !m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;

    `DWCF_ASSERT_IMP(a_set_le_all, 1'b1, set_reg <= all_reg,
        "nonzero count exceeds pixel count")
    `DWCF_ASSERT_NEXT(a_hit_counts, hit_reg && !cmd.start,
        all_reg == $past(all_reg) + dwcf_pkg::CNT_W'(1), "window hit not counted")
    `DWCF_ASSERT_NEXT(a_div_armed, cmd.div_load,
        div_cnt_reg == dwcf_pkg::DCNT_W'(dwcf_pkg::NUM_W), "divider not armed on load")

endmodule

// ----- bench/dwcf_result_checker.sv -----
// Scoreboard for the disc coverage filter: mirrors the mask store and config registers,
// predicts each query's filtered_value and compares the result stream against it.
// Depends on dwcf_pkg.
module dwcf_result_checker
    import dwcf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [7:0]            m_axis_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    mismatches
);

    bit                  mask_bits [0:DEPTH-1];
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [RADCFG_W-1:0] radius_reg;
    logic [OUT_W-1:0]    coverage_q [$];
    int                  error_total = 0;

    function automatic int span_in_use(logic [DIM_W-1:0] v, int limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return int'(v);
    endfunction

    // Count in-image disc pixels and the set ones among them, scale to full range.
    function automatic logic [OUT_W-1:0] disc_coverage(int cx, int cy);
        int w, h, r, x, y, dx, dy, total, lit;
        w = span_in_use(width_reg, MAX_WIDTH);
        h = span_in_use(height_reg, MAX_HEIGHT);
        r = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
        total = 0;
        lit = 0;
        if (cx >= w || cy >= h) return '0;
        for (dy = -r; dy <= r; dy++) begin
            for (dx = -r; dx <= r; dx++) begin
                x = cx + dx;
                y = cy + dy;
                if (x >= 0 && x < w && y >= 0 && y < h && dx * dx + dy * dy <= r * r) begin
                    total++;
                    if (mask_bits[y * MAX_WIDTH + x]) lit++;
                end
            end
        end
        return OUT_W'((lit * FULL_SCALE) / total);
    endfunction

    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        logic [COL_W-1:0] beat_col;
        logic [ROW_W-1:0] beat_row;
        logic [PIX_W-1:0] beat_pix;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            radius_reg = RADIUS_RESET;
            coverage_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data;
                    CFG_DISC_RADIUS:  radius_reg = cfg_data[RADCFG_W-1:0];
                    default: ;
                endcase
            end
            // Retire the oldest expectation before queuing a new one.
            if (m_axis_tvalid && m_axis_tready) begin
                if (coverage_q.size() == 0) begin
                    $error("filtered_value: no result expected, actual %0d", m_axis_tdata);
                    error_total++;
                end else begin
                    want = coverage_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("filtered_value mismatch: expected %0d actual %0d",
                               want, m_axis_tdata);
                        error_total++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                beat_col = s_axis_tdata[5:0];
                beat_row = s_axis_tdata[11:6];
                beat_pix = s_axis_tdata[19:12];
                if (s_axis_tuser == MODE_QUERY)
                    coverage_q = {coverage_q, disc_coverage(beat_col, beat_row)};
                else if (beat_col < span_in_use(width_reg, MAX_WIDTH) &&
                         beat_row < span_in_use(height_reg, MAX_HEIGHT))
                    mask_bits[{beat_row, beat_col}] = (beat_pix != 0);
            end
        end
        pending    <= coverage_q.size();
        mismatches <= error_total;
    end

endmodule

// ----- bench/tb_disk_window_coverage_filter_unit.sv -----
// Top of the disc coverage filter bench: clock, reset, stimulus and verdict.
// Depends on dwcf_pkg, dwcf_result_checker and disk_window_coverage_filter_unit.
module tb_disk_window_coverage_filter_unit;
    import dwcf_pkg::*;

    // Longest stretch without any beat; it must cover a radius-15 query.
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 64;
    localparam int GAP_PERCENT   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = MODE_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int pending;
    int mismatches;

    // Stimulus-side view of the image: which cells hold a loaded value, and the
    // dimensions and radius in effect, so no query ever touches an unloaded cell.
    bit loaded_map [0:DEPTH-1];
    int cur_w = MAX_WIDTH;
    int cur_h = MAX_HEIGHT;
    int cur_r = 1;
    int items_sent = 0;
    int fill_density = 50;
    bit calm = 1'b0;
    int idle_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    disk_window_coverage_filter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dwcf_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    // Receiver back-pressure: random stalls, none while a calm phase runs.
    always @(posedge aclk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= GAP_PERCENT);
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [PIX_W-1:0] random_pixel();
        if ($urandom_range(99) < fill_density) return PIX_W'($urandom_range(255, 1));
        return '0;
    endfunction

    // Offer one input beat, with an occasional idle gap ahead of it; hold until taken.
    task automatic send_beat(input logic mode, input int c, input int rw,
                             input logic [PIX_W-1:0] pix);
        if (!calm && $urandom_range(99) < GAP_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, pix, ROW_W'(rw), COL_W'(c)};
        do @(posedge aclk); while (!s_axis_tready);
        // Off-image loads are dropped by the block and do not count as items.
        if (mode == MODE_QUERY || (c < cur_w && rw < cur_h)) items_sent++;
        if (mode == MODE_LOAD && c < cur_w && rw < cur_h) loaded_map[rw * MAX_WIDTH + c] = 1'b1;
    endtask

    // For an in-image (c, rw), load every unloaded in-image cell of its disc; then query (c, rw).
    task automatic query_at(input int c, input int rw);
        int dx, dy, x, y;
        if (c < cur_w && rw < cur_h) begin
            for (dy = -cur_r; dy <= cur_r; dy++) begin
                for (dx = -cur_r; dx <= cur_r; dx++) begin
                    x = c + dx;
                    y = rw + dy;
                    if (x >= 0 && x < cur_w && y >= 0 && y < cur_h &&
                        dx * dx + dy * dy <= cur_r * cur_r && !loaded_map[y * MAX_WIDTH + x])
                        send_beat(MODE_LOAD, x, y, random_pixel());
                end
            end
        end
        send_beat(MODE_QUERY, c, rw, PIX_W'($urandom));
    endtask

    // Drop valid and hold until every queued query has returned its beat.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Reprogram all registers once the block is idle; raw values may be out of
    // range, in which case the block clamps them.
    task automatic apply_setting(input int w, input int h, input int r, input bit poke_unused);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_beat(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_beat(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        // Upper bits of the radius write are don't-care; randomize them.
        cfg_beat(CFG_DISC_RADIUS, {3'($urandom_range(7)), 4'(r)});
        if (poke_unused) cfg_beat(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
        cur_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
        cur_r = (r > MAX_RADIUS) ? MAX_RADIUS : r;
    endtask

    // One random phase: mostly in-image loads and queries, some off-image noise.
    task automatic run_phase(input int w, input int h, input int r, input int n, input bit quiet);
        int first, pick, c, rw;
        apply_setting(w, h, r, 1'b0);
        fill_density = $urandom_range(100);
        calm = quiet;
        first = items_sent;
        while (items_sent - first < n) begin
            pick = $urandom_range(99);
            if (pick < 16 && (cur_w < MAX_WIDTH || cur_h < MAX_HEIGHT)) begin
                if (cur_h == MAX_HEIGHT || (cur_w < MAX_WIDTH && $urandom_range(1))) begin
                    c  = $urandom_range(63, cur_w);
                    rw = $urandom_range(63);
                end else begin
                    c  = $urandom_range(63);
                    rw = $urandom_range(63, cur_h);
                end
                if (pick < 8) send_beat(MODE_LOAD, c, rw, PIX_W'($urandom));
                else query_at(c, rw);
            end else begin
                c  = $urandom_range(cur_w - 1);
                rw = $urandom_range(cur_h - 1);
                if (pick < 55) send_beat(MODE_LOAD, c, rw, random_pixel());
                else query_at(c, rw);
            end
            // Now and then starve the block until all results are out.
            if ($urandom_range(99) == 0) wait_drained();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Far corner under the reset setting (64x64, radius 1): two of three set.
        send_beat(MODE_LOAD, 63, 63, 8'hFF);
        send_beat(MODE_LOAD, 62, 63, 8'h00);
        send_beat(MODE_LOAD, 63, 62, 8'h01);
        query_at(63, 63);
        // Origin corner: one of three set.
        send_beat(MODE_LOAD, 0, 0, 8'h80);
        send_beat(MODE_LOAD, 1, 0, 8'h00);
        send_beat(MODE_LOAD, 0, 1, 8'h00);
        query_at(0, 0);

        // Zero dimensions clamp to a single pixel; widest radius; unused index.
        apply_setting(0, 0, MAX_RADIUS, 1'b1);
        send_beat(MODE_LOAD, 1, 0, 8'h7F);
        query_at(0, 0);
        query_at(63, 63);
        query_at(0, 1);

        // Oversized dimensions clamp to the full store; radius zero sees the center only.
        apply_setting(127, 127, 0, 1'b0);
        query_at(63, 63);
        query_at(62, 63);
        send_beat(MODE_LOAD, 21, 42, 8'h55);
        query_at(21, 42);
        send_beat(MODE_LOAD, 21, 42, 8'h00);
        query_at(21, 42);

        // Random phases; the 32x32 one runs with no random input gaps or output stalls.
        run_phase(1, 64, 4, 40, 1'b0);
        run_phase(64, 1, 15, 40, 1'b0);
        run_phase(5, 7, 0, 50, 1'b0);
        run_phase(12, 9, 2, 120, 1'b0);
        run_phase(32, 32, 1, 100, 1'b1);
        run_phase(20, 16, 5, 70, 1'b0);
        run_phase(64, 64, 2, 100, 1'b0);
        run_phase(8, 8, 15, 30, 1'b0);
        run_phase(3, 40, 7, 40, 1'b0);
        run_phase(0, 96, 3, 30, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
